@@ hdl/crcfe_pkg.sv @@
`default_nettype none

package crcfe_pkg;

  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] CrcInit   = 8'h00;
  localparam logic [7:0] IdReset   = 8'h31;
  localparam logic [7:0] LenExtra  = 8'd2;
  localparam int         HdrBits   = 24;
  localparam int         WrSlots   = 5;

  localparam logic [1:0] AddrMsgId = 2'd0;

  localparam logic [2:0] CntPass   = 3'd1;
  localparam logic [2:0] CntHeader = 3'd4;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic                      en;
    logic [2:0]                cnt;
    entry_t [WrSlots-1:0]      ent;
  } qwr_t;

  // one byte into the crc, msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ CrcPoly) : (v << 1);
    end
    return v;
  endfunction

  // crc contribution of one bit of the header word {len, id, data}, zero init
  function automatic logic [7:0] crc8_hdr_col(input int g);
    logic [HdrBits-1:0] w;
    logic [7:0]         c;
    logic               fb;
    w = HdrBits'(1) << g;
    c = CrcInit;
    for (int k = HdrBits - 1; k >= 0; k--) begin
      fb = c[7] ^ w[k];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crc8_atm_frame_encoder.sv @@
`default_nettype none

// Frame builder: payload bytes in, framed bytes out (0x02, length+2, message
// id, payload..., CRC-8-ATM over length, id and payload, tlast on the CRC).
// Each input transaction is framed into a six-entry output queue that drains
// one byte per cycle while out_tready is high; passed-through bytes sustain
// one transaction per cycle likewise. A transaction is taken while at most
// one byte is queued, so a frame's first byte (four or five bytes out) and a
// byte followed by the CRC hold the input until one byte is left. Message id
// is read at byte address 0 and sampled on each frame's first byte.
module crc8_atm_frame_encoder #(
  parameter int MAX_PAYLOAD = 250
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [7:0] payload_byte, [15:8] payload_length
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] tx_byte
  output logic             out_tlast,   // frame_end
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import crcfe_pkg::*;

  localparam logic [7:0] MaxLen   = 8'(MAX_PAYLOAD);

  logic [7:0]         id_r;
  logic [7:0]         pos_r, pos_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         len_r, len_nxt;
  logic               in_fire;
  logic               start;
  logic [7:0]         data_b;
  logic [7:0]         len_in;
  logic [7:0]         len_sat;
  logic [7:0]         len_byte;
  logic [7:0]         len_cur;
  logic [7:0]         pos_inc;
  logic [7:0]         crc_pass;
  logic [7:0]         crc_hdr;
  logic [7:0]         crc_new;
  logic [HdrBits-1:0] hdr_word;
  logic [7:0]         col_term [HdrBits];
  logic               ends;
  qwr_t               wr;

  assign data_b  = in_tdata[7:0];
  assign len_in  = in_tdata[15:8];
  assign in_fire = in_tvalid && in_tready;
  assign start   = (pos_r == 8'd0);

  always_comb begin
    len_sat = len_in;
    if (len_sat == 8'd0) len_sat = 8'd1;
    if (len_sat > MaxLen) len_sat = MaxLen;
  end
  assign len_byte = len_sat + LenExtra;

  // header crc as a linear map of {len, id, data}
  assign hdr_word = {len_byte, id_r, data_b};
  for (genvar g = 0; g < HdrBits; g++) begin : g_col
    localparam logic [7:0] Col = crc8_hdr_col(g);
    assign col_term[g] = hdr_word[g] ? Col : 8'h00;
  end

  always_comb begin
    crc_hdr = CrcInit;
    for (int i = 0; i < HdrBits; i++) begin
      crc_hdr = crc_hdr ^ col_term[i];
    end
  end

  assign crc_pass = crc8_feed(crc_r, data_b);
  assign crc_new  = start ? crc_hdr : crc_pass;
  assign len_cur  = start ? len_sat : len_r;
  assign pos_inc  = start ? 8'd1 : pos_r + 8'd1;
  assign ends     = (pos_inc >= len_cur);

  always_comb begin
    wr        = '0;
    wr.en     = in_fire;
    if (start) begin
      wr.ent[0] = '{last: 1'b0, data: StartByte};
      wr.ent[1] = '{last: 1'b0, data: len_byte};
      wr.ent[2] = '{last: 1'b0, data: id_r};
      wr.ent[3] = '{last: 1'b0, data: data_b};
      wr.ent[4] = '{last: 1'b1, data: crc_new};
      wr.cnt    = CntHeader + {2'b00, ends};
    end else begin
      wr.ent[0] = '{last: 1'b0, data: data_b};
      wr.ent[1] = '{last: 1'b1, data: crc_new};
      wr.cnt    = CntPass + {2'b00, ends};
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    len_nxt = len_r;
    if (in_fire) begin
      len_nxt = len_cur;
      if (ends) begin
        pos_nxt = 8'd0;
        crc_nxt = CrcInit;
      end else begin
        pos_nxt = pos_inc;
        crc_nxt = crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CrcInit;
      len_r <= '0;
      id_r  <= IdReset;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      len_r <= len_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == AddrMsgId) begin
        id_r <= cfg_pwdata[7:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrMsgId) ? {24'd0, id_r} : 32'd0;

  crcfe_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .in_room    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 8'd0 |-> (pos_r < len_r && len_r <= MaxLen))
    else $error("byte position outside frame");

  a_idle_crc: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == 8'd0 |-> crc_r == CrcInit)
    else $error("crc not cleared between frames");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ends) |=> pos_r == 8'd0)
    else $error("frame not closed after crc");

endmodule

`default_nettype wire

@@ hdl/crcfe_out_queue.sv @@
`default_nettype none

module crcfe_out_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire crcfe_pkg::qwr_t wr,
  output logic                in_room,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,   // tx_byte
  output logic                out_tlast    // frame_end
);
  import crcfe_pkg::*;

  localparam int Depth = WrSlots + 1;

  entry_t     slot_r [Depth];
  entry_t     slot_nxt [Depth];
  entry_t     wr_ext [Depth];
  entry_t     wr_sh [Depth];
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic [2:0] rem;
  logic       fire;

  assign fire       = out_tvalid && out_tready;
  assign rem        = count_r - {2'b00, fire};
  assign in_room    = (count_r <= 3'd1);
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = slot_r[0].data;
  assign out_tlast  = slot_r[0].last;

  for (genvar g = 0; g < WrSlots; g++) begin : g_wr
    assign wr_ext[g]  = wr.ent[g];
    assign wr_sh[g+1] = wr.ent[g];
  end
  assign wr_ext[Depth-1] = '0;
  assign wr_sh[0]        = '0;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (fire && i < Depth - 1) begin
        slot_nxt[i] = slot_r[(i < Depth - 1) ? i + 1 : i];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if (wr.en) begin
        if (rem == 3'd0) begin
          if (i < 32'(wr.cnt)) slot_nxt[i] = wr_ext[i];
        end else begin
          if (i >= 1 && i <= 32'(wr.cnt)) slot_nxt[i] = wr_sh[i];
        end
      end
    end
    count_nxt = rem + (wr.en ? wr.cnt : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(Depth))
    else $error("queue count beyond depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (count_r <= 3'd1 && wr.cnt != 3'd0 && wr.cnt <= 3'(WrSlots)))
    else $error("queue write without room");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !wr.en) |=> count_r == $past(count_r) - 3'd1)
    else $error("queue drain miscounted");

endmodule

`default_nettype wire

@@ tb/crc8_atm_frame_encoder_tb.sv @@
`default_nettype none

module crc8_atm_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfe_pkg::*;

  localparam int         MaxPayload = 250;
  localparam int         HoldCycles = 400;
  localparam int         CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } tx_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [7:0] payload_byte, [15:8] payload_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] tx_byte
  logic        out_tlast;        // frame_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [15:0] byte_feed_q[$];
  tx_beat_t    tx_exp_q[$];

  logic [7:0]  msg_id_m = IdReset;
  logic [7:0]  pos_m = '0;
  logic [7:0]  crc_m = CrcInit;
  logic [7:0]  len_m = '0;

  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;

  crc8_atm_frame_encoder #(.MAX_PAYLOAD(MaxPayload)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // CRC-8-ATM, bit at a time
  function automatic logic [7:0] crc8_atm(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       top;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      top = r[7] ^ b[i];
      r   = {r[6:0], 1'b0} ^ (top ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic fe);
    tx_beat_t t;
    t.tx_byte   = b;
    t.frame_end = fe;
    tx_exp_q.push_back(t);
  endfunction

  function automatic void frame_bytes_predict(input logic [7:0] pb, input logic [7:0] plen);
    logic [7:0] n;
    logic [7:0] lb;
    if (pos_m == 8'd0) begin
      n = (plen == 8'd0) ? 8'd1 : ((plen > MaxPayload) ? 8'(MaxPayload) : plen);
      lb = n + LenExtra;
      len_m = n;
      crc_m = crc8_atm(crc8_atm(crc8_atm(CrcInit, lb), msg_id_m), pb);
      push_beat(StartByte, 1'b0);
      push_beat(lb, 1'b0);
      push_beat(msg_id_m, 1'b0);
      push_beat(pb, 1'b0);
      pos_m = 8'd1;
    end else begin
      crc_m = crc8_atm(crc_m, pb);
      push_beat(pb, 1'b0);
      pos_m = pos_m + 8'd1;
    end
    if (pos_m >= len_m) begin
      push_beat(crc_m, 1'b1);
      pos_m = 8'd0;
      crc_m = CrcInit;
    end
  endfunction

  // first transaction carries the length field, the rest carry noise there
  function automatic void queue_frame(input logic [7:0] plen, input logic [7:0] first_byte,
                                      input bit rand_first);
    int n;
    n = (plen == 8'd0) ? 1 : ((plen > MaxPayload) ? MaxPayload : int'(plen));
    byte_feed_q.push_back({plen, rand_first ? 8'($urandom) : first_byte});
    for (int i = 1; i < n; i++) byte_feed_q.push_back(16'($urandom));
  endfunction

  function automatic void queue_random_frames(input int items);
    int k;
    logic [7:0] plen;
    k = 0;
    while (k < items) begin
      plen = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 24)) : 8'($urandom_range(1, 6));
      queue_frame(plen, 8'h00, 1'b1);
      k += (plen == 8'd0) ? 1 : int'(plen);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) frame_bytes_predict(in_tdata[7:0], in_tdata[15:8]);
      if (!in_tvalid || in_tready) begin
        if (byte_feed_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= byte_feed_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tx_beat_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (tx_exp_q.size() == 0) begin
          $error("unexpected transaction: tx_byte=%02h frame_end=%0b", out_tdata, out_tlast);
          errors++;
        end else begin
          e = tx_exp_q.pop_front();
          if (out_tdata !== e.tx_byte) begin
            $error("tx_byte: expected %02h, actual %02h", e.tx_byte, out_tdata);
            errors++;
          end
          if (out_tlast !== e.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", e.frame_end, out_tlast);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done  <= 1'b1;
        hold_left  <= HoldCycles;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (byte_feed_q.size() != 0 || in_tvalid || tx_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic read_msg_id();
    @(posedge clk);
    cfg_psel   <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr  <= AddrMsgId;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[7:0] !== msg_id_m) begin
      $error("message_id: expected %02h, actual %02h", msg_id_m, cfg_prdata[7:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_msg_id(input logic [7:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AddrMsgId;
    cfg_pwdata  <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    msg_id_m = v;
    read_msg_id();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    read_msg_id();

    // directed, reset message id
    queue_frame(8'd1, 8'h00, 1'b0);
    queue_frame(8'd0, 8'hFF, 1'b0);
    byte_feed_q.push_back({8'd2, 8'hFF});
    byte_feed_q.push_back({8'hFF, 8'h00});
    byte_feed_q.push_back({8'd3, 8'h55});
    byte_feed_q.push_back({8'h00, 8'hAA});
    byte_feed_q.push_back({8'h81, 8'h80});
    wait_drained();

    write_msg_id(8'h00);
    queue_frame(8'd1, 8'h80, 1'b0);
    queue_frame(8'd4, 8'h01, 1'b0);
    wait_drained();

    write_msg_id(8'hFF);
    queue_frame(8'd1, 8'h7F, 1'b0);
    queue_frame(8'd5, 8'hFE, 1'b0);
    queue_frame(8'd2, 8'h00, 1'b1);
    wait_drained();

    // random, normal idling
    write_msg_id(8'($urandom));
    queue_random_frames(30);
    wait_drained();

    // receiver holds off while frames keep coming
    write_msg_id(8'($urandom));
    hold_go <= 1'b1;
    queue_random_frames(25);
    wait_drained();

    // no idling on either side
    calm <= 1'b1;
    write_msg_id(8'($urandom));
    queue_random_frames(25);
    wait_drained();
    calm <= 1'b0;

    repeat (20) @(posedge clk);
    if (tx_exp_q.size() != 0) begin
      $error("%0d expected transactions never arrived", tx_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/crcfe_pkg.sv
hdl/crcfe_out_queue.sv
hdl/crc8_atm_frame_encoder.sv
tb/crc8_atm_frame_encoder_tb.sv
